/* design/dual_deploy_recovery_sequencer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the dual-deploy recovery sequencer.
// Each macro expects clk and rst_n to be visible in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef DUAL_DEPLOY_RECOVERY_SEQUENCER_ASSERT_SVH
`define DUAL_DEPLOY_RECOVERY_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DDRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ddrs_pkg.sv */
// ---------------------------------------------------------------------------
// ddrs_pkg
// Types and constants shared by the recovery sequencer modules.
// ---------------------------------------------------------------------------
package ddrs_pkg;

  // Flight phases.
  typedef enum logic [2:0] {
    PH_WAIT_APOGEE = 3'd0,
    PH_APOGEE_FIRE = 3'd1,
    PH_WAIT_MAIN   = 3'd2,
    PH_MAIN_FIRE   = 3'd3,
    PH_DONE        = 3'd4
  } phase_t;

  // Register indexes (word address bits [3:2]).
  localparam logic [1:0] REG_APOGEE_DROP   = 2'd0;
  localparam logic [1:0] REG_MAIN_ALTITUDE = 2'd1;
  localparam logic [1:0] REG_FIRE_DELAY    = 2'd2;
  localparam logic [1:0] REG_PULSE_LENGTH  = 2'd3;

  // Register reset values.
  localparam logic [15:0]        RST_APOGEE_DROP   = 16'd30;
  localparam logic signed [23:0] RST_MAIN_ALTITUDE = 24'sd3000;
  localparam logic [15:0]        RST_FIRE_DELAY    = 16'd0;
  localparam logic [15:0]        RST_PULSE_LENGTH  = 16'd1000;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned CNT_W  = 17;

  typedef struct packed {
    logic               req_type;
    logic signed [23:0] altitude;
    logic               accel_lock;
  } in_item_t;

  typedef struct packed {
    logic       apogee_drive;
    logic       main_drive;
    logic       apogee_trigger;
    logic       main_trigger;
    logic [2:0] phase_now;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        apogee_drop;
    logic signed [23:0] main_altitude;
    logic [15:0]        fire_delay;
    logic [15:0]        pulse_length;
  } cfg_t;

endpackage

/* design/dual_deploy_recovery_sequencer.sv */
// ---------------------------------------------------------------------------
// dual_deploy_recovery_sequencer
// Apogee and main deployment sequencer driven by altitude samples and ticks.
// ---------------------------------------------------------------------------
// Usage: each transfer on the input channel (in_valid/in_stall/in_data) is
// either an altitude sample or a one millisecond tick. Every accepted
// transfer produces exactly one result transfer on the output channel
// (out_valid/out_stall/out_data) carrying the pin levels, the trigger flags
// and the phase after that item.
// The item is captured in the input register when it is accepted, and the
// flight state and the result register are updated when it is processed;
// the result is offered from the result register after that update.
// Throughput is one item per clock while the receiver does not stall. The
// only loop is the state register of ddrs_core, closed by combinational logic.
// When the receiver stalls, the result register holds its transfer and the
// input register keeps the item behind it; in_stall rises only when both
// registers are occupied, so no item is lost or repeated.
// Reset (synchronous, rst_n low) puts the sequencer in the apogee wait with
// peak, last sample and timer cleared, and loads the register defaults.
// The registers are written through the APB-style port at word addresses
// 0x0, 0x4, 0x8, 0xC and should only be changed while the block is idle.
// ---------------------------------------------------------------------------
module dual_deploy_recovery_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ddrs_pkg::in_item_t            in_data,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output ddrs_pkg::out_item_t           out_data,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddrs_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  ddrs_pkg::cfg_t      cfg;
  ddrs_pkg::in_item_t  in_item_r;
  logic                in_valid_r;
  ddrs_pkg::out_item_t out_data_r;
  ddrs_pkg::out_item_t core_res;
  logic                out_valid_r;
  logic                adv;
  logic                proc;
  logic                in_take;

  ddrs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The result register can take a new value when it is empty or is being
  // drained in this cycle.
  assign adv      = !out_valid_r || !out_stall;
  // The held item is processed whenever the result register can take it.
  assign proc     = in_valid_r && adv;
  // The input register is free unless it holds an item that cannot move on.
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  ddrs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (proc),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (proc) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= proc;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (proc) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "dual_deploy_recovery_sequencer_assert.svh"

  // An apogee trigger always comes with the apogee firing phase.
  `DDRS_ASSERT_IMP(a_apo_trig_phase, out_valid_r && out_data_r.apogee_trigger,
                   out_data_r.phase_now == 3'(ddrs_pkg::PH_APOGEE_FIRE),
                   "apogee trigger outside firing phase")
  // A processed item always shows up in the result register next cycle.
  `DDRS_ASSERT_NXT(a_proc_to_out, proc, out_valid_r,
                   "processed item did not reach result register")
  // The input side stalls only when both stages are full and the output stalls.
  `DDRS_ASSERT_IMP(a_stall_cause, in_stall, in_valid_r && out_valid_r && out_stall,
                   "input stalled without a full pipeline")

endmodule

/* design/ddrs_cfg_regs.sv */
// ---------------------------------------------------------------------------
// ddrs_cfg_regs
// APB-style configuration registers for the recovery sequencer.
// ---------------------------------------------------------------------------
module ddrs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddrs_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ddrs_pkg::cfg_t                cfg
);

  ddrs_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.apogee_drop   <= ddrs_pkg::RST_APOGEE_DROP;
      cfg_r.main_altitude <= ddrs_pkg::RST_MAIN_ALTITUDE;
      cfg_r.fire_delay    <= ddrs_pkg::RST_FIRE_DELAY;
      cfg_r.pulse_length  <= ddrs_pkg::RST_PULSE_LENGTH;
    end else if (wr_en) begin
      unique case (reg_idx)
        ddrs_pkg::REG_APOGEE_DROP:   cfg_r.apogee_drop   <= pwdata[15:0];
        ddrs_pkg::REG_MAIN_ALTITUDE: cfg_r.main_altitude <= $signed(pwdata[23:0]);
        ddrs_pkg::REG_FIRE_DELAY:    cfg_r.fire_delay    <= pwdata[15:0];
        ddrs_pkg::REG_PULSE_LENGTH:  cfg_r.pulse_length  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data; the signed altitude threshold comes back sign-extended.
  always_comb begin
    unique case (reg_idx)
      ddrs_pkg::REG_APOGEE_DROP:   prdata = {16'd0, cfg_r.apogee_drop};
      ddrs_pkg::REG_MAIN_ALTITUDE: prdata = {{8{cfg_r.main_altitude[23]}},
                                             cfg_r.main_altitude};
      ddrs_pkg::REG_FIRE_DELAY:    prdata = {16'd0, cfg_r.fire_delay};
      ddrs_pkg::REG_PULSE_LENGTH:  prdata = {16'd0, cfg_r.pulse_length};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

/* design/ddrs_core.sv */
// ---------------------------------------------------------------------------
// ddrs_core
// Flight state and next-state logic: peak tracking, apogee and main
// detection, and the delay/pulse timer of each firing.
// ---------------------------------------------------------------------------
module ddrs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  ddrs_pkg::in_item_t  item,
  input  ddrs_pkg::cfg_t      cfg,
  output ddrs_pkg::out_item_t res
);

  localparam int unsigned CW = ddrs_pkg::CNT_W;

  ddrs_pkg::phase_t   phase_r, phase_nxt;
  logic signed [23:0] peak_r, peak_nxt;
  logic signed [23:0] last_r, last_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               pin_r, pin_nxt;
  logic               apo_trig, main_trig;

  logic [CW-1:0]      cnt_inc;
  logic [15:0]        plen;
  logic signed [25:0] drop;
  logic               firing;

  assign cnt_inc = cnt_r + CW'(1);
  assign plen    = (cfg.pulse_length == 16'd0) ? 16'd1 : cfg.pulse_length;
  assign drop    = 26'(peak_r) - 26'(item.altitude);
  assign firing  = (phase_r == ddrs_pkg::PH_APOGEE_FIRE) ||
                   (phase_r == ddrs_pkg::PH_MAIN_FIRE);

  always_comb begin
    phase_nxt = phase_r;
    peak_nxt  = peak_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    pin_nxt   = pin_r;
    apo_trig  = 1'b0;
    main_trig = 1'b0;
    if (item.req_type) begin
      if (firing) begin
        cnt_nxt = cnt_inc;
        if (!pin_r) begin
          if (cnt_inc >= CW'(cfg.fire_delay)) begin
            pin_nxt = 1'b1;
            cnt_nxt = '0;
          end
        end else if (cnt_inc >= CW'(plen)) begin
          pin_nxt   = 1'b0;
          cnt_nxt   = '0;
          phase_nxt = (phase_r == ddrs_pkg::PH_APOGEE_FIRE) ? ddrs_pkg::PH_WAIT_MAIN
                                                            : ddrs_pkg::PH_DONE;
        end
      end
    end else begin
      unique case (phase_r)
        ddrs_pkg::PH_WAIT_APOGEE: begin
          if (!item.accel_lock) begin
            if (drop > $signed({10'd0, cfg.apogee_drop})) begin
              apo_trig  = 1'b1;
              phase_nxt = ddrs_pkg::PH_APOGEE_FIRE;
              cnt_nxt   = '0;
              pin_nxt   = (cfg.fire_delay == 16'd0);
            end else if (last_r <= item.altitude && peak_r < item.altitude) begin
              peak_nxt = item.altitude;
            end
            last_nxt = item.altitude;
          end
        end
        ddrs_pkg::PH_WAIT_MAIN: begin
          if (item.altitude <= cfg.main_altitude) begin
            main_trig = 1'b1;
            phase_nxt = ddrs_pkg::PH_MAIN_FIRE;
            cnt_nxt   = '0;
            pin_nxt   = (cfg.fire_delay == 16'd0);
          end
          last_nxt = item.altitude;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ddrs_pkg::PH_WAIT_APOGEE;
      peak_r  <= '0;
      last_r  <= '0;
      cnt_r   <= '0;
      pin_r   <= 1'b0;
    end else if (go) begin
      phase_r <= phase_nxt;
      peak_r  <= peak_nxt;
      last_r  <= last_nxt;
      cnt_r   <= cnt_nxt;
      pin_r   <= pin_nxt;
    end
  end

  assign res.apogee_drive   = (phase_nxt == ddrs_pkg::PH_APOGEE_FIRE) && pin_nxt;
  assign res.main_drive     = (phase_nxt == ddrs_pkg::PH_MAIN_FIRE) && pin_nxt;
  assign res.apogee_trigger = apo_trig;
  assign res.main_trigger   = main_trig;
  assign res.phase_now      = 3'(phase_nxt);

  `include "dual_deploy_recovery_sequencer_assert.svh"

  // A tick never ends the wait for apogee.
  `DDRS_ASSERT_NXT(a_tick_keeps_wait,
                   go && item.req_type && (phase_r == ddrs_pkg::PH_WAIT_APOGEE),
                   phase_r == ddrs_pkg::PH_WAIT_APOGEE, "tick left apogee wait")
  // The pin is only ever high during a firing.
  `DDRS_ASSERT_IMP(a_pin_in_firing, pin_r, firing, "pin high outside a firing")
  // The phase stays within the defined codes.
  `DDRS_ASSERT_IMP(a_phase_legal, 1'b1, phase_r <= ddrs_pkg::PH_DONE, "illegal phase code")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: dual-deploy recovery sequencer testbench
// Flies one complete flight through the sequencer. Altitude samples and ticks
// are queued by a stimulus process, sent by a clocked driver, and every
// result transfer is checked field by field against an in-bench flight
// predictor. Registers are rewritten between flight segments while the block
// is idle, and both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  ddrs_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ddrs_pkg::out_item_t out_data;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ddrs_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  dual_deploy_recovery_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Items waiting to be sent, and outcomes waiting to be seen on the output.
  ddrs_pkg::in_item_t  pending_items[$];
  ddrs_pkg::out_item_t pending_outcomes[$];

  int n_pushed = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_apogee_seen = 0;
  int n_main_seen = 0;

  // Idle percentages for each side; the stimulus process changes them per
  // flight segment.
  int send_idle_pct = 25;
  int recv_idle_pct = 59;

  // The stimulus process toggles hold_req to ask the receiver for one long
  // hold-off; the receiver counts it down on its own.
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  // Shadow of the flight state and of the register file.
  ddrs_pkg::cfg_t      flight_cfg;
  ddrs_pkg::phase_t    fl_phase;
  int                  fl_peak;
  int                  fl_last;
  logic [16:0]         fl_count;
  logic                fl_pin;

  ddrs_pkg::out_item_t step_outcome;
  ddrs_pkg::out_item_t seen_outcome;

  // Clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a transfer.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("dual_deploy_recovery_sequencer verification failed");
    $finish;
  end

  // A firing starts with the counter cleared; with no delay the pin is high
  // on the very item that triggered.
  task automatic start_firing(input ddrs_pkg::phase_t firing);
    fl_phase = firing;
    fl_count = '0;
    fl_pin   = (flight_cfg.fire_delay == 16'd0);
  endtask

  // One item through the flight predictor. It returns the state after the
  // item, as the block reports it.
  task automatic predict_flight_step(input ddrs_pkg::in_item_t it,
                                     output ddrs_pkg::out_item_t r);
    logic        apo_hit;
    logic        main_hit;
    int          cur;
    int          descent;
    int          main_level;
    logic [16:0] plen;
    apo_hit    = 1'b0;
    main_hit   = 1'b0;
    cur        = {{8{it.altitude[23]}}, it.altitude};
    main_level = {{8{flight_cfg.main_altitude[23]}}, flight_cfg.main_altitude};
    plen       = (flight_cfg.pulse_length == 16'd0) ? 17'd1
                                                    : {1'b0, flight_cfg.pulse_length};
    if (it.req_type) begin
      // Ticks only matter while a charge is being fired.
      if (fl_phase == ddrs_pkg::PH_APOGEE_FIRE || fl_phase == ddrs_pkg::PH_MAIN_FIRE) begin
        fl_count = fl_count + 17'd1;
        if (!fl_pin) begin
          if (fl_count >= {1'b0, flight_cfg.fire_delay}) begin
            fl_pin   = 1'b1;
            fl_count = '0;
          end
        end else if (fl_count >= plen) begin
          fl_pin   = 1'b0;
          fl_count = '0;
          if (fl_phase == ddrs_pkg::PH_APOGEE_FIRE) begin
            fl_phase = ddrs_pkg::PH_WAIT_MAIN;
          end else begin
            fl_phase = ddrs_pkg::PH_DONE;
          end
        end
      end
    end else if (fl_phase == ddrs_pkg::PH_WAIT_APOGEE) begin
      // A locked sample leaves peak and last sample untouched.
      if (!it.accel_lock) begin
        descent = fl_peak - cur;
        if (descent > int'(flight_cfg.apogee_drop)) begin
          apo_hit = 1'b1;
          start_firing(ddrs_pkg::PH_APOGEE_FIRE);
        end else if (fl_last <= cur && fl_peak < cur) begin
          fl_peak = cur;
        end
        fl_last = cur;
      end
    end else if (fl_phase == ddrs_pkg::PH_WAIT_MAIN) begin
      if (cur <= main_level) begin
        main_hit = 1'b1;
        start_firing(ddrs_pkg::PH_MAIN_FIRE);
      end
      fl_last = cur;
    end
    r.apogee_drive   = (fl_phase == ddrs_pkg::PH_APOGEE_FIRE) && fl_pin;
    r.main_drive     = (fl_phase == ddrs_pkg::PH_MAIN_FIRE) && fl_pin;
    r.apogee_trigger = apo_hit;
    r.main_trigger   = main_hit;
    r.phase_now      = fl_phase;
  endtask

  task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Driver. A transfer completes at an edge with in_valid high and in_stall
  // low; the predictor runs on it right there. A stalled item is held as is,
  // otherwise the next pending item is offered unless the sender idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_flight_step(in_data, step_outcome);
        pending_outcomes.push_back(step_outcome);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver. Every result transfer is matched to the oldest
  // outcome; then the stall for the next cycle is chosen.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_data.apogee_trigger) n_apogee_seen++;
      if (out_data.main_trigger) n_main_seen++;
      if (pending_outcomes.size() == 0) begin
        $display("%0t ns: result transfer with no outcome waiting, expected none, actual %h",
                 $time, out_data);
        n_errors++;
      end else begin
        seen_outcome = pending_outcomes.pop_front();
        check_field("apogee_drive", 3'(seen_outcome.apogee_drive), 3'(out_data.apogee_drive));
        check_field("main_drive", 3'(seen_outcome.main_drive), 3'(out_data.main_drive));
        check_field("apogee_trigger", 3'(seen_outcome.apogee_trigger),
                    3'(out_data.apogee_trigger));
        check_field("main_trigger", 3'(seen_outcome.main_trigger), 3'(out_data.main_trigger));
        check_field("phase_now", seen_outcome.phase_now, out_data.phase_now);
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic push_item(input logic tick, input logic [23:0] alt, input logic lock);
    ddrs_pkg::in_item_t it;
    it.req_type   = tick;
    it.altitude   = alt;
    it.accel_lock = lock;
    pending_items.push_back(it);
    n_pushed++;
  endtask

  task automatic push_tick();
    push_item(1'b1, 24'($urandom), 1'($urandom));
  endtask

  // Wait until every queued item has produced its result, then let the
  // pipeline drain before anything else happens.
  task automatic settle();
    wait (n_results == n_pushed);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, access cycle; the register takes the value at the edge that
  // ends the access cycle, which is where the shadow copy is updated too.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unique case (idx)
      ddrs_pkg::REG_APOGEE_DROP:   flight_cfg.apogee_drop   = value[15:0];
      ddrs_pkg::REG_MAIN_ALTITUDE: flight_cfg.main_altitude = value[23:0];
      ddrs_pkg::REG_FIRE_DELAY:    flight_cfg.fire_delay    = value[15:0];
      ddrs_pkg::REG_PULSE_LENGTH:  flight_cfg.pulse_length  = value[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] drop, input logic [23:0] main_alt,
                           input logic [15:0] delay, input logic [15:0] plen);
    write_reg(ddrs_pkg::REG_APOGEE_DROP, {16'd0, drop});
    write_reg(ddrs_pkg::REG_MAIN_ALTITUDE, {{8{main_alt[23]}}, main_alt});
    write_reg(ddrs_pkg::REG_FIRE_DELAY, {16'd0, delay});
    write_reg(ddrs_pkg::REG_PULSE_LENGTH, {16'd0, plen});
  endtask

  // Stimulus: one flight, split into segments with a register setting each.
  initial begin
    int alt_w;
    int top;
    int roll;
    logic [23:0] rnd;

    flight_cfg.apogee_drop   = ddrs_pkg::RST_APOGEE_DROP;
    flight_cfg.main_altitude = ddrs_pkg::RST_MAIN_ALTITUDE;
    flight_cfg.fire_delay    = ddrs_pkg::RST_FIRE_DELAY;
    flight_cfg.pulse_length  = ddrs_pkg::RST_PULSE_LENGTH;
    fl_phase = ddrs_pkg::PH_WAIT_APOGEE;
    fl_peak  = 0;
    fl_last  = 0;
    fl_count = '0;
    fl_pin   = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed climb under the reset registers (drop of 30). Locked samples
    // at both altitude extremes and early ticks must change nothing.
    push_item(1'b0, 24'h7FFFFF, 1'b1);
    push_item(1'b0, 24'h800000, 1'b1);
    push_item(1'b1, 24'h000000, 1'b0);
    push_item(1'b1, 24'hFFFFFF, 1'b1);
    push_item(1'b0, 24'd0, 1'b0);
    push_item(1'b0, 24'd10, 1'b0);     // new peak
    push_item(1'b0, 24'd5, 1'b0);      // dip
    push_item(1'b0, 24'd7, 1'b0);      // rising but still under the peak
    push_item(1'b0, 24'd10, 1'b0);     // equal to the peak, no raise
    push_item(1'b0, 24'd20, 1'b0);     // new peak
    push_item(1'b0, -24'sd10, 1'b0);   // descent of exactly the drop: no apogee
    push_item(1'b0, 24'd25, 1'b0);     // rising from below, new peak
    push_item(1'b0, 24'd25, 1'b0);
    settle();

    // Long coast in the apogee wait with every register at its maximum. The
    // unlocked samples stay within a band narrower than the drop, so apogee
    // cannot fire; locked samples cover the whole altitude range.
    write_all(16'hFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
    alt_w = 25;
    for (int i = 0; i < 300; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        push_tick();
      end else if (roll < 35) begin
        push_item(1'b0, 24'($urandom), 1'b1);
      end else begin
        if (roll < 40) begin
          alt_w = $urandom_range(0, 60000) - 30000;
        end else begin
          alt_w = alt_w + $urandom_range(0, 500) - 220;
        end
        if (alt_w > 30000) alt_w = 30000;
        if (alt_w < -30000) alt_w = -30000;
        push_item(1'b0, 24'(alt_w), 1'b0);
      end
    end
    settle();

    // Apogee with no fire delay and a zero pulse length (one tick), then a
    // main wait at the lowest main altitude, which random samples avoid.
    send_idle_pct = 59;
    recv_idle_pct = 25;
    write_all(16'd100, 24'h800000, 16'd0, 16'd0);
    // The band's top pins both peak and last sample to a known value.
    top = 30000;
    push_item(1'b0, 24'(top), 1'b0);
    for (int i = 0; i < 20; i++) begin
      if (i % 7 == 3) begin
        push_item(1'b0, 24'($urandom), 1'b1);
      end else if (i % 5 == 2) begin
        push_item(1'b0, 24'(top), 1'b0);
      end else begin
        top = top + $urandom_range(1, 60);
        push_item(1'b0, 24'(top), 1'b0);
      end
    end
    push_tick();
    push_item(1'b0, 24'(top - 30), 1'b0);
    push_item(1'b0, 24'(top - 100), 1'b0);   // exactly the drop: no apogee
    push_item(1'b0, 24'(top - 101), 1'b0);   // apogee, pin high at once
    push_item(1'b0, 24'($urandom), 1'b0);    // ignored while firing
    push_tick();                             // pulse over, main wait
    push_item(1'b0, 24'h800001, 1'b0);       // one above the main level
    for (int i = 0; i < 200; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        push_tick();
      end else begin
        rnd = 24'($urandom);
        if (rnd == 24'h800000) rnd = 24'h800001;
        push_item(1'b0, rnd, 1'($urandom));
      end
    end
    settle();

    // Main deployment at the main level itself, with a delay of three ticks
    // and a pulse of four, then the done phase, where everything is ignored.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(16'd0, 24'd1000, 16'd3, 16'd4);
    push_item(1'b0, 24'd1001, 1'b0);
    push_item(1'b0, 24'd1000, 1'b1);         // main fires on equality
    push_tick();
    push_item(1'b0, 24'($urandom), 1'b0);    // ignored while firing
    push_tick();
    push_tick();                             // delay over, pin high
    for (int i = 0; i < 4; i++) begin
      push_tick();
      if (i == 1) push_item(1'b0, 24'd0, 1'b0);
    end
    for (int i = 0; i < 150; i++) begin
      push_item(1'($urandom), 24'($urandom), 1'($urandom));
    end
    // A long receiver hold-off while the sender keeps offering back to back.
    hold_req = ~hold_req;
    settle();

    $display("Flight covered: %0d items sent, %0d results checked.", n_pushed, n_results);
    $display("Apogee triggers seen: %0d, main triggers seen: %0d, final phase %0d.",
             n_apogee_seen, n_main_seen, fl_phase);
    if (n_errors == 0 && pending_outcomes.size() == 0) begin
      $display("dual_deploy_recovery_sequencer verification clean");
    end else begin
      $display("dual_deploy_recovery_sequencer verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/ddrs_pkg.sv
design/ddrs_cfg_regs.sv
design/ddrs_core.sv
design/dual_deploy_recovery_sequencer.sv
dv/tb_top.sv
